FILE: design/c_like_lexer_core_defines.svh
// ----------------------------------------------------------------------------
// c_like_lexer_core_defines: assertion macros for the lexer core
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef C_LIKE_LEXER_CORE_DEFINES_SVH
`define C_LIKE_LEXER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CLX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lexer core check failed");

// Next-cycle implication.
`define CLX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lexer core check failed");

// Invariant that holds in every cycle out of reset.
`define CLX_ASSERT_ALWAYS(lbl, cond) \
	`CLX_ASSERT_NOW(lbl, 1'b1, cond)

`endif

FILE: design/clx_pkg.sv
// ----------------------------------------------------------------------------
// clx_pkg: shared types and constants of the lexer core
// Token kinds, scan modes, character codes, the token record and the
// character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package clx_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF   = 16;
	localparam int FIELD_W           = 16;
	localparam int KIND_W            = 4;
	localparam int MAX_RES           = 3;
	localparam int CNT_W             = 2;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t K_IDENT   = 4'd0;
	localparam kind_t K_INT     = 4'd1;
	localparam kind_t K_FLOAT   = 4'd2;
	localparam kind_t K_STRING  = 4'd3;
	localparam kind_t K_CHAR    = 4'd4;
	localparam kind_t K_LPAREN  = 4'd5;
	localparam kind_t K_RPAREN  = 4'd6;
	localparam kind_t K_COMMA   = 4'd7;
	localparam kind_t K_SEMI    = 4'd8;
	localparam kind_t K_EQUALS  = 4'd9;
	localparam kind_t K_OP      = 4'd10;
	localparam kind_t K_UNKNOWN = 4'd11;
	localparam kind_t K_EOF     = 4'd12;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_E_LOWER    = 8'h65;
	localparam logic [7:0] CH_E_UPPER    = 8'h45;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_SQUOTE     = 8'h27;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_0          = 8'h30;
	localparam logic [7:0] CH_9          = 8'h39;
	localparam logic [7:0] CH_A_LOWER    = 8'h61;
	localparam logic [7:0] CH_Z_LOWER    = 8'h7A;
	localparam logic [7:0] CH_A_UPPER    = 8'h41;
	localparam logic [7:0] CH_Z_UPPER    = 8'h5A;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_EQUALS     = 8'h3D;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_PIPE       = 8'h7C;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_COLON      = 8'h3A;

	typedef enum logic [8:0] {
		M_IDLE     = 9'b000000001,
		M_IDENT    = 9'b000000010,
		M_INT      = 9'b000000100,
		M_INTDOT   = 9'b000001000,
		M_FRAC     = 9'b000010000,
		M_EXPSTART = 9'b000100000,
		M_EXPDIG   = 9'b001000000,
		M_QUOTE    = 9'b010000000,
		M_QESC     = 9'b100000000
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] sl;
		logic [FIELD_W-1:0] sc;
		logic [FIELD_W-1:0] el;
		logic [FIELD_W-1:0] ec;
		logic [FIELD_W-1:0] len;
	} token_t;

	typedef struct packed {
		token_t [MAX_RES-1:0] tok;
		logic [CNT_W-1:0]     cnt;
	} step_res_t;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

	function automatic logic is_ident_start(logic [7:0] b);
		return ((b >= CH_A_LOWER) && (b <= CH_Z_LOWER)) ||
			((b >= CH_A_UPPER) && (b <= CH_Z_UPPER)) || (b == CH_UNDERSCORE);
	endfunction

	function automatic logic is_ident_part(logic [7:0] b);
		return is_ident_start(b) || is_digit(b);
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic kind_t single_kind(logic [7:0] b);
		kind_t k;
		unique case (b)
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_COMMA:  k = K_COMMA;
			CH_SEMI:   k = K_SEMI;
			CH_EQUALS: k = K_EQUALS;
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_LT, CH_GT,
			CH_BANG, CH_AMP, CH_PIPE, CH_CARET, CH_DOT, CH_COLON: k = K_OP;
			default:   k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: design/clx_step.sv
// ----------------------------------------------------------------------------
// clx_step: scan state and per-word token logic
// Holds the scan mode and position counters and, for one input word,
// works out in a single pass the up to three tokens it closes.
// ----------------------------------------------------------------------------
`default_nettype none

module clx_step #(
	parameter int POSITION_BITS = clx_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = clx_pkg::LENGTH_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step_en,
	input  wire logic [7:0]        byte_in,
	input  wire logic              end_of_source,
	output clx_pkg::step_res_t     res
);

	localparam int PW   = POSITION_BITS;
	localparam int LW   = LENGTH_BITS;
	localparam int PWX  = (PW > clx_pkg::FIELD_W) ? PW : clx_pkg::FIELD_W;
	localparam int LWX  = (LW > clx_pkg::FIELD_W) ? LW : clx_pkg::FIELD_W;
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
	localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
	localparam logic [PW-1:0] POS_ONE = PW'(1);

	typedef struct packed {
		logic [PW-1:0] line;
		logic [PW-1:0] col;
		logic [LW-1:0] cnt;
	} pos_t;

	// Move the position over one byte, saturating every counter.
	function automatic pos_t adv(pos_t p, logic [7:0] b);
		pos_t q;
		q = p;
		if (b == clx_pkg::CH_LF) begin
			if (p.line != POS_MAX)
				q.line = p.line + POS_ONE;
			q.col = POS_ONE;
		end else if (p.col != POS_MAX) begin
			q.col = p.col + POS_ONE;
		end
		if (p.cnt != LEN_MAX)
			q.cnt = p.cnt + LW'(1);
		return q;
	endfunction

	function automatic logic [clx_pkg::FIELD_W-1:0] pos16(logic [PW-1:0] v);
		logic [PWX-1:0] w;
		w = PWX'(v);
		return w[clx_pkg::FIELD_W-1:0];
	endfunction

	function automatic logic [clx_pkg::FIELD_W-1:0] len16(logic [LW-1:0] v);
		logic [LWX-1:0] w;
		w = LWX'(v);
		return w[clx_pkg::FIELD_W-1:0];
	endfunction

	function automatic clx_pkg::token_t mk_tok(clx_pkg::kind_t k, logic [PW-1:0] sl,
		logic [PW-1:0] sc, logic [PW-1:0] el, logic [PW-1:0] ec, logic [LW-1:0] len);
		clx_pkg::token_t t;
		t.kind = k;
		t.sl   = pos16(sl);
		t.sc   = pos16(sc);
		t.el   = pos16(el);
		t.ec   = pos16(ec);
		t.len  = len16(len);
		return t;
	endfunction

	clx_pkg::mode_t mode_q, m_d;
	logic           qs_q, qs_d;
	pos_t           pos_q, p_d;
	logic [PW-1:0]  tl_q, tc_q, tl_d, tc_d;
	logic [1:0]     n_d;
	logic           taken_d;
	logic [7:0]     qend_d;

	// Walk one word through the scanner.
	always_comb begin
		m_d     = mode_q;
		qs_d    = qs_q;
		p_d     = pos_q;
		tl_d    = tl_q;
		tc_d    = tc_q;
		n_d     = '0;
		taken_d = 1'b1;
		res     = '0;
		qend_d  = qs_q ? clx_pkg::CH_SQUOTE : clx_pkg::CH_DQUOTE;

		if (end_of_source) begin
			// Flush the open token.
			unique case (mode_q)
				clx_pkg::M_IDENT: begin
					res.tok[n_d] = mk_tok(clx_pkg::K_IDENT, tl_d, tc_d, p_d.line,
						p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
				end
				clx_pkg::M_INT: begin
					res.tok[n_d] = mk_tok(clx_pkg::K_INT, tl_d, tc_d, p_d.line,
						p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
				end
				clx_pkg::M_INTDOT: begin
					res.tok[n_d] = mk_tok(clx_pkg::K_INT, tl_d, tc_d, p_d.line,
						p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
					tl_d = p_d.line;
					tc_d = p_d.col;
					p_d.cnt = '0;
					p_d = adv(p_d, clx_pkg::CH_DOT);
					res.tok[n_d] = mk_tok(clx_pkg::K_OP, tl_d, tc_d, p_d.line,
						p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
				end
				clx_pkg::M_FRAC, clx_pkg::M_EXPSTART, clx_pkg::M_EXPDIG: begin
					res.tok[n_d] = mk_tok(clx_pkg::K_FLOAT, tl_d, tc_d, p_d.line,
						p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
				end
				clx_pkg::M_QUOTE, clx_pkg::M_QESC: begin
					res.tok[n_d] = mk_tok(qs_q ? clx_pkg::K_CHAR : clx_pkg::K_STRING,
						tl_d, tc_d, p_d.line, p_d.col - POS_ONE, p_d.cnt);
					n_d = n_d + 2'd1;
				end
				default: begin
				end
			endcase
			// Emit end of file, then restart the position.
			res.tok[n_d] = mk_tok(clx_pkg::K_EOF, p_d.line, p_d.col, p_d.line,
				p_d.col, '0);
			n_d  = n_d + 2'd1;
			m_d  = clx_pkg::M_IDLE;
			qs_d = 1'b0;
			p_d  = '{line: POS_ONE, col: POS_ONE, cnt: '0};
			tl_d = POS_ONE;
			tc_d = POS_ONE;
		end else begin
			unique case (mode_q)
				clx_pkg::M_IDENT: begin
					if (clx_pkg::is_ident_part(byte_in)) begin
						p_d = adv(p_d, byte_in);
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::K_IDENT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_INT: begin
					if (clx_pkg::is_digit(byte_in)) begin
						p_d = adv(p_d, byte_in);
					end else if (byte_in == clx_pkg::CH_DOT) begin
						m_d = clx_pkg::M_INTDOT;
					end else if (byte_in == clx_pkg::CH_E_LOWER ||
						byte_in == clx_pkg::CH_E_UPPER) begin
						p_d = adv(p_d, byte_in);
						m_d = clx_pkg::M_EXPSTART;
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::K_INT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_INTDOT: begin
					if (clx_pkg::is_digit(byte_in)) begin
						p_d = adv(p_d, clx_pkg::CH_DOT);
						p_d = adv(p_d, byte_in);
						m_d = clx_pkg::M_FRAC;
					end else begin
						// Integer, then the held dot as an operator.
						res.tok[n_d] = mk_tok(clx_pkg::K_INT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						tl_d = p_d.line;
						tc_d = p_d.col;
						p_d.cnt = '0;
						p_d = adv(p_d, clx_pkg::CH_DOT);
						res.tok[n_d] = mk_tok(clx_pkg::K_OP, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_FRAC: begin
					if (clx_pkg::is_digit(byte_in)) begin
						p_d = adv(p_d, byte_in);
					end else if (byte_in == clx_pkg::CH_E_LOWER ||
						byte_in == clx_pkg::CH_E_UPPER) begin
						p_d = adv(p_d, byte_in);
						m_d = clx_pkg::M_EXPSTART;
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::K_FLOAT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_EXPSTART: begin
					if (byte_in == clx_pkg::CH_PLUS || byte_in == clx_pkg::CH_MINUS ||
						clx_pkg::is_digit(byte_in)) begin
						p_d = adv(p_d, byte_in);
						m_d = clx_pkg::M_EXPDIG;
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::K_FLOAT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_EXPDIG: begin
					if (clx_pkg::is_digit(byte_in)) begin
						p_d = adv(p_d, byte_in);
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::K_FLOAT, tl_d, tc_d, p_d.line,
							p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
						taken_d = 1'b0;
					end
				end
				clx_pkg::M_QUOTE: begin
					p_d = adv(p_d, byte_in);
					if (byte_in == clx_pkg::CH_BACKSLASH) begin
						m_d = clx_pkg::M_QESC;
					end else if (byte_in == qend_d || byte_in == clx_pkg::CH_LF) begin
						res.tok[n_d] = mk_tok(qs_q ? clx_pkg::K_CHAR : clx_pkg::K_STRING,
							tl_d, tc_d, p_d.line, p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
					end
				end
				clx_pkg::M_QESC: begin
					p_d = adv(p_d, byte_in);
					m_d = clx_pkg::M_QUOTE;
				end
				default: begin
					m_d = clx_pkg::M_IDLE;
					taken_d = 1'b0;
				end
			endcase

			// Start a new token from an idle scanner.
			if (!taken_d) begin
				if (clx_pkg::is_space(byte_in)) begin
					p_d = adv(p_d, byte_in);
				end else begin
					tl_d = p_d.line;
					tc_d = p_d.col;
					p_d.cnt = '0;
					p_d = adv(p_d, byte_in);
					if (clx_pkg::is_ident_start(byte_in)) begin
						m_d = clx_pkg::M_IDENT;
					end else if (clx_pkg::is_digit(byte_in)) begin
						m_d = clx_pkg::M_INT;
					end else if (byte_in == clx_pkg::CH_DQUOTE ||
						byte_in == clx_pkg::CH_SQUOTE) begin
						qs_d = (byte_in == clx_pkg::CH_SQUOTE);
						m_d  = clx_pkg::M_QUOTE;
					end else begin
						res.tok[n_d] = mk_tok(clx_pkg::single_kind(byte_in), tl_d, tc_d,
							p_d.line, p_d.col - POS_ONE, p_d.cnt);
						n_d = n_d + 2'd1;
						m_d = clx_pkg::M_IDLE;
					end
				end
			end
		end
		res.cnt = n_d;
	end

	// Advance the scan state when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= clx_pkg::M_IDLE;
			qs_q   <= 1'b0;
			pos_q  <= '{line: POS_ONE, col: POS_ONE, cnt: '0};
			tl_q   <= POS_ONE;
			tc_q   <= POS_ONE;
		end else if (step_en) begin
			mode_q <= m_d;
			qs_q   <= qs_d;
			pos_q  <= p_d;
			tl_q   <= tl_d;
			tc_q   <= tc_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/c_like_lexer_core.sv
// ----------------------------------------------------------------------------
// c_like_lexer_core: byte-serial lexer for C-like source text
// Tracks line and column and reports each token's kind, span and length.
// ----------------------------------------------------------------------------
// Input channel: one word is a source byte with an end-of-source flag, taken
//   when in_valid is high and in_stall low. End of source flushes the open
//   token, emits an end-of-file token and restarts at line 1, column 1.
// Output channel: one word is a token, taken when out_valid is high and
//   out_stall low; last_result marks the final token caused by an input word.
// Path: a word is registered in the input register, scanned into the result
//   buffer once that buffer is free, and its tokens show on the output from it.
// Throughput: one input word per cycle while each word yields at most one
//   token and the output does not stall; a word that yields several tokens
//   holds the result buffer until the single output port has drained them.
// Stall: while the receiver stalls, the buffered tokens hold and one more
//   input word is still taken into the input register; further words stall.
// Reset: arst_n clears the scanner to idle at line 1, column 1 and empties
//   both registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_like_lexer_core_defines.svh"

module c_like_lexer_core #(
	parameter int POSITION_BITS = clx_pkg::POSITION_BITS_DEF,
	parameter int LENGTH_BITS   = clx_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      byte_in,
	input  wire logic                            end_of_source,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [clx_pkg::KIND_W-1:0]           token_kind,
	output logic [clx_pkg::FIELD_W-1:0]          start_line,
	output logic [clx_pkg::FIELD_W-1:0]          start_column,
	output logic [clx_pkg::FIELD_W-1:0]          end_line,
	output logic [clx_pkg::FIELD_W-1:0]          end_column,
	output logic [clx_pkg::FIELD_W-1:0]          token_length,
	output logic                                 last_result
);

	logic                        vld_s1;
	logic [7:0]                  byte_s1;
	logic                        eos_s1;
	logic                        in_acc;
	logic                        out_acc;
	logic                        grp_free;
	logic                        step_en;
	clx_pkg::step_res_t          res;
	clx_pkg::token_t             grp_q [clx_pkg::MAX_RES];
	logic [clx_pkg::CNT_W-1:0]   cnt_q;
	logic [clx_pkg::CNT_W-1:0]   rd_q;
	clx_pkg::token_t             cur_tok;

	// Handshakes and buffer hand-off.
	assign out_valid = (rd_q != cnt_q);
	assign last_result = (rd_q == (cnt_q - 2'd1));
	assign out_acc   = out_valid && !out_stall;
	assign grp_free  = !out_valid || (out_acc && last_result);
	assign step_en   = vld_s1 && grp_free;
	assign in_stall  = vld_s1 && !grp_free;
	assign in_acc    = in_valid && !in_stall;

	clx_step #(
		.POSITION_BITS (POSITION_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.byte_in       (byte_s1),
		.end_of_source (eos_s1),
		.res           (res)
	);

	// Hold the input word valid until the scanner takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (step_en) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_source;
		end
	end

	// Load a token group, then drain it one word at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (step_en) begin
			cnt_q <= res.cnt;
			rd_q  <= '0;
		end else if (out_acc) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			for (int i = 0; i < clx_pkg::MAX_RES; i++)
				grp_q[i] <= res.tok[i];
		end
	end

	assign cur_tok      = grp_q[rd_q];
	assign token_kind   = cur_tok.kind;
	assign start_line   = cur_tok.sl;
	assign start_column = cur_tok.sc;
	assign end_line     = cur_tok.el;
	assign end_column   = cur_tok.ec;
	assign token_length = cur_tok.len;

	// End of source always yields at least the end-of-file token.
	`CLX_ASSERT_NOW(a_eos_emits, step_en && eos_s1, res.cnt != 2'd0)
	// Three tokens only come from an integer with a held dot.
	`CLX_ASSERT_NOW(a_three_has_dot, step_en && res.cnt == 2'd3,
		res.tok[1].kind == clx_pkg::K_OP && res.tok[0].kind == clx_pkg::K_INT)
	// The read pointer never passes the group size.
	`CLX_ASSERT_ALWAYS(a_rd_in_range, rd_q <= cnt_q)
	// Draining the last token with nothing new leaves the output empty.
	`CLX_ASSERT_NEXT(a_drain_empty, out_acc && last_result && !step_en, !out_valid)

endmodule

`default_nettype wire

FILE: sim/c_like_lexer_core_token_checker.sv
// ----------------------------------------------------------------------------
// c_like_lexer_core_token_checker: token predictor and comparator
// Watches both channels of the lexer core. Every accepted input word is run
// through an independent scanner model that queues the tokens it should
// cause; every accepted output word is compared field by field with the
// oldest queued token. Reports the mismatch count and the tokens still owed.
// ----------------------------------------------------------------------------
module c_like_lexer_core_token_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    byte_in,
	input  logic                          end_of_source,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [clx_pkg::KIND_W-1:0]    token_kind,
	input  logic [clx_pkg::FIELD_W-1:0]   start_line,
	input  logic [clx_pkg::FIELD_W-1:0]   start_column,
	input  logic [clx_pkg::FIELD_W-1:0]   end_line,
	input  logic [clx_pkg::FIELD_W-1:0]   end_column,
	input  logic [clx_pkg::FIELD_W-1:0]   token_length,
	input  logic                          last_result,
	output int                            fail_count,
	output int                            pending
);

	import clx_pkg::*;

	typedef logic [POSITION_BITS_DEF-1:0] pos_t;
	typedef logic [LENGTH_BITS_DEF-1:0]   count_t;

	typedef struct packed {
		token_t tok;
		logic   last;
	} lex_token_t;

	// scanner state
	mode_t  scan;
	logic   single_quote;
	pos_t   line_now;
	pos_t   col_now;
	pos_t   tok_line;
	pos_t   tok_col;
	count_t tok_bytes;

	lex_token_t word_tokens[$];
	lex_token_t expected_tokens[$];

	function automatic logic digit_byte(logic [7:0] b);
		return b inside {[CH_0:CH_9]};
	endfunction

	function automatic logic word_start_byte(logic [7:0] b);
		logic [7:0] folded;
		folded = b | 8'h20;
		return (folded >= CH_A_LOWER && folded <= CH_Z_LOWER) || b == CH_UNDERSCORE;
	endfunction

	function automatic kind_t punct_kind(logic [7:0] b);
		case (b)
			CH_LPAREN: return K_LPAREN;
			CH_RPAREN: return K_RPAREN;
			CH_COMMA:  return K_COMMA;
			CH_SEMI:   return K_SEMI;
			CH_EQUALS: return K_EQUALS;
			CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_LT, CH_GT,
			CH_BANG, CH_AMP, CH_PIPE, CH_CARET, CH_DOT, CH_COLON: return K_OP;
			default:   return K_UNKNOWN;
		endcase
	endfunction

	function automatic kind_t quoted_kind();
		return single_quote ? K_CHAR : K_STRING;
	endfunction

	function automatic void reset_scanner();
		scan = M_IDLE;
		single_quote = 1'b0;
		line_now = pos_t'(1);
		col_now = pos_t'(1);
		tok_line = pos_t'(1);
		tok_col = pos_t'(1);
		tok_bytes = '0;
	endfunction

	// Advance position and byte count, saturating.
	function automatic void step_pos(logic [7:0] b);
		if (b == CH_LF) begin
			if (line_now != '1)
				line_now = line_now + 1'b1;
			col_now = pos_t'(1);
		end else if (col_now != '1) begin
			col_now = col_now + 1'b1;
		end
		if (tok_bytes != '1)
			tok_bytes = tok_bytes + 1'b1;
	endfunction

	function automatic void mark_start();
		tok_line = line_now;
		tok_col = col_now;
		tok_bytes = '0;
	endfunction

	function automatic void put_token(kind_t k, pos_t sl, pos_t sc, pos_t el, pos_t ec,
		count_t n);
		lex_token_t t;
		if (word_tokens.size() < MAX_RES) begin
			t.tok.kind = k;
			t.tok.sl = FIELD_W'(sl);
			t.tok.sc = FIELD_W'(sc);
			t.tok.el = FIELD_W'(el);
			t.tok.ec = FIELD_W'(ec);
			t.tok.len = FIELD_W'(n);
			t.last = 1'b0;
			word_tokens = {word_tokens, t};
		end
	endfunction

	function automatic void close_token(kind_t k);
		put_token(k, tok_line, tok_col, line_now, col_now - 1'b1, tok_bytes);
		scan = M_IDLE;
	endfunction

	// Emit the integer, then the held dot as an operator of its own.
	function automatic void close_int_then_dot();
		close_token(K_INT);
		mark_start();
		step_pos(CH_DOT);
		close_token(K_OP);
	endfunction

	function automatic void begin_byte(logic [7:0] b);
		if (b inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
			step_pos(b);
		end else begin
			mark_start();
			step_pos(b);
			if (word_start_byte(b)) begin
				scan = M_IDENT;
			end else if (digit_byte(b)) begin
				scan = M_INT;
			end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
				single_quote = (b == CH_SQUOTE);
				scan = M_QUOTE;
			end else begin
				close_token(punct_kind(b));
			end
		end
	endfunction

	// Predict the tokens caused by one input word.
	function automatic void lex_word(logic [7:0] b, logic eos);
		logic taken;
		word_tokens.delete();
		if (eos) begin
			case (scan)
				M_IDENT:                      close_token(K_IDENT);
				M_INT:                        close_token(K_INT);
				M_INTDOT:                     close_int_then_dot();
				M_FRAC, M_EXPSTART, M_EXPDIG: close_token(K_FLOAT);
				M_QUOTE, M_QESC:              close_token(quoted_kind());
				default:                      ;
			endcase
			put_token(K_EOF, line_now, col_now, line_now, col_now, '0);
			reset_scanner();
		end else begin
			taken = 1'b1;
			case (scan)
				M_IDENT: begin
					if (word_start_byte(b) || digit_byte(b)) begin
						step_pos(b);
					end else begin
						close_token(K_IDENT);
						taken = 1'b0;
					end
				end
				M_INT: begin
					if (digit_byte(b)) begin
						step_pos(b);
					end else if (b == CH_DOT) begin
						scan = M_INTDOT;
					end else if (b == CH_E_LOWER || b == CH_E_UPPER) begin
						step_pos(b);
						scan = M_EXPSTART;
					end else begin
						close_token(K_INT);
						taken = 1'b0;
					end
				end
				M_INTDOT: begin
					if (digit_byte(b)) begin
						step_pos(CH_DOT);
						step_pos(b);
						scan = M_FRAC;
					end else begin
						close_int_then_dot();
						taken = 1'b0;
					end
				end
				M_FRAC: begin
					if (digit_byte(b)) begin
						step_pos(b);
					end else if (b == CH_E_LOWER || b == CH_E_UPPER) begin
						step_pos(b);
						scan = M_EXPSTART;
					end else begin
						close_token(K_FLOAT);
						taken = 1'b0;
					end
				end
				M_EXPSTART: begin
					if (b == CH_PLUS || b == CH_MINUS || digit_byte(b)) begin
						step_pos(b);
						scan = M_EXPDIG;
					end else begin
						close_token(K_FLOAT);
						taken = 1'b0;
					end
				end
				M_EXPDIG: begin
					if (digit_byte(b)) begin
						step_pos(b);
					end else begin
						close_token(K_FLOAT);
						taken = 1'b0;
					end
				end
				M_QUOTE: begin
					step_pos(b);
					if (b == CH_BACKSLASH)
						scan = M_QESC;
					else if (b == (single_quote ? CH_SQUOTE : CH_DQUOTE) || b == CH_LF)
						close_token(quoted_kind());
				end
				M_QESC: begin
					step_pos(b);
					scan = M_QUOTE;
				end
				default: begin
					scan = M_IDLE;
					taken = 1'b0;
				end
			endcase
			if (!taken)
				begin_byte(b);
		end
		if (word_tokens.size() > 0)
			word_tokens[word_tokens.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, word_tokens};
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count = fail_count + 1;
		end
	endfunction

	// Compare the outgoing word first, then predict from the incoming one.
	always @(posedge clk or negedge arst_n) begin
		lex_token_t head;
		if (!arst_n) begin
			reset_scanner();
			expected_tokens.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: token mismatch, expected none, actual kind %0d line %0d col %0d",
						$time, token_kind, start_line, start_column);
					fail_count = fail_count + 1;
				end else begin
					head = expected_tokens.pop_front();
					check_field("token_kind", int'(head.tok.kind), int'(token_kind));
					check_field("start_line", int'(head.tok.sl), int'(start_line));
					check_field("start_column", int'(head.tok.sc), int'(start_column));
					check_field("end_line", int'(head.tok.el), int'(end_line));
					check_field("end_column", int'(head.tok.ec), int'(end_column));
					check_field("token_length", int'(head.tok.len), int'(token_length));
					check_field("last_result", int'(head.last), int'(last_result));
				end
			end
			if (in_valid && !in_stall)
				lex_word(byte_in, end_of_source);
		end
		pending = expected_tokens.size();
	end

endmodule

FILE: sim/c_like_lexer_core_tb.sv
// ----------------------------------------------------------------------------
// c_like_lexer_core_tb: top-level testbench of the lexer core
// Drives a short directed source text, then random well-formed token
// fragments mixed with noise and end-of-source words, with random gaps on
// the input and random stalls on the output. The token checker beside the
// core predicts and compares.
// ----------------------------------------------------------------------------
module c_like_lexer_core_tb;

	import clx_pkg::*;

	localparam int RUN_LIMIT    = 12 * 900000;
	localparam int RANDOM_WORDS = 320;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_in = 8'h00;
	logic        end_of_source = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [KIND_W-1:0]  token_kind;
	logic [FIELD_W-1:0] start_line;
	logic [FIELD_W-1:0] start_column;
	logic [FIELD_W-1:0] end_line;
	logic [FIELD_W-1:0] end_column;
	logic [FIELD_W-1:0] token_length;
	logic        last_result;

	int   fail_count;
	int   pending;
	logic calm = 1'b0;
	int   stall_left = 0;
	int   words_sent = 0;
	string punct_chars = "(),;=+-*/%<>!&|^.:";

	c_like_lexer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.start_line    (start_line),
		.start_column  (start_column),
		.end_line      (end_line),
		.end_column    (end_column),
		.token_length  (token_length),
		.last_result   (last_result)
	);

	c_like_lexer_core_token_checker token_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_in       (byte_in),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.start_line    (start_line),
		.start_column  (start_column),
		.end_line      (end_line),
		.end_column    (end_column),
		.token_length  (token_length),
		.last_result   (last_result),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the output at random: mostly short, now and then long.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < 30) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_word_start();
		case ($urandom_range(0, 4))
			0:       return CH_UNDERSCORE;
			1, 2:    return 8'(CH_A_LOWER + $urandom_range(0, 25));
			default: return 8'(CH_A_UPPER + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_blank();
		return 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	// Present one word after an optional gap and hold it until accepted.
	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		end_of_source <= eos;
		do @(posedge clk); while (in_stall);
		words_sent = words_sent + 1;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic send_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			send_word(rand_digit(), 1'b0);
	endtask

	// Send one random token fragment, sometimes followed by a blank.
	task automatic send_fragment();
		logic [7:0] q;
		case ($urandom_range(0, 11))
			0, 1: begin
				send_word(rand_word_start(), 1'b0);
				repeat ($urandom_range(0, 5))
					send_word($urandom_range(0, 2) == 0 ? rand_digit() : rand_word_start(), 1'b0);
			end
			2: send_digits(1, 4);
			3, 4: begin
				send_digits(1, 3);
				if ($urandom_range(0, 1)) begin
					send_word(CH_DOT, 1'b0);
					send_digits(1, 3);
				end
				if ($urandom_range(0, 1)) begin
					send_word($urandom_range(0, 1) ? CH_E_LOWER : CH_E_UPPER, 1'b0);
					if ($urandom_range(0, 1))
						send_word($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
					send_digits(0, 2);
				end
			end
			5: begin
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				send_word(q, 1'b0);
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 4) == 0) begin
						send_word(CH_BACKSLASH, 1'b0);
						send_word(rand_byte(), 1'b0);
					end else begin
						send_word(8'($urandom_range(32, 126)), 1'b0);
					end
				end
				send_word($urandom_range(0, 6) == 0 ? CH_LF : q, 1'b0);
			end
			6: send_word(punct_chars[$urandom_range(0, punct_chars.len() - 1)], 1'b0);
			7: send_word(rand_byte(), 1'b0);
			8: begin
				send_digits(1, 2);
				send_word(CH_DOT, 1'b0);
				send_word($urandom_range(0, 1) ? rand_word_start() :
					punct_chars[$urandom_range(0, punct_chars.len() - 1)], 1'b0);
			end
			9: send_word(CH_LF, 1'b0);
			10: begin
				if ($urandom_range(0, 3) == 0)
					send_word(rand_byte(), 1'b1);
				else
					send_word(punct_chars[$urandom_range(0, 4)], 1'b0);
			end
			default: send_word(rand_blank(), 1'b0);
		endcase
		if ($urandom_range(0, 1))
			send_word($urandom_range(0, 3) == 0 ? rand_blank() : CH_SPACE, 1'b0);
	endtask

	// Abort a hung run.
	initial begin
		#(RUN_LIMIT);
		$display("c_like_lexer_core_tb NOT OK");
		$finish;
	end

	initial begin
		int start_count;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every token kind but the left parenthesis, dot lookahead,
		// bare exponent, escaped newline, string cut by newline, odd bytes, flush at end
		send_text("_z9 ");
		send_text("1.5e-3,");
		send_text("7.;");
		send_text("1e)");
		send_text("'\\\n'");
		send_text("\"a\n");
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h7F, 1'b0);
		send_text("=4.");
		send_word(8'hA5, 1'b1);

		// random fragments, with quiet stretches now and then
		start_count = words_sent;
		while (words_sent - start_count < RANDOM_WORDS) begin
			if ($urandom_range(0, 19) == 0)
				calm <= !calm;
			send_fragment();
		end
		send_word(8'h00, 1'b1);
		in_valid <= 1'b0;
		calm <= 1'b0;

		// drain, then give stray tokens a chance to show
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("c_like_lexer_core_tb OK");
		else
			$display("c_like_lexer_core_tb NOT OK");
		$finish;
	end

endmodule
